>>> sv/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

	localparam int BLK_FIELD_W = 8;
	localparam int OFF_FIELD_W = 24;

	typedef logic [1:0] op_t;
	typedef logic [1:0] status_t;

	localparam op_t OP_ALLOC   = 2'd0;
	localparam op_t OP_RESTORE = 2'd1;
	localparam op_t OP_RELEASE = 2'd2;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_NULL      = 2'd1;
	localparam status_t ST_TOO_LARGE = 2'd2;
	localparam status_t ST_NO_BLOCKS = 2'd3;

	typedef struct packed {
		status_t                  status;
		logic [BLK_FIELD_W-1:0]   alloc_block;
		logic [OFF_FIELD_W-1:0]   alloc_offset;
	} result_t;

endpackage
`default_nettype wire

>>> sv/bba_step.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_step #(
	parameter int BLOCK_BYTES_LOG2 = 23,
	parameter int MAX_BLOCKS       = 256,
	parameter int BLK_W            = 8,
	parameter int OFF_W            = 24
) (
	input  var bba_pkg::op_t            operation,
	input  var logic [3:0]              align_log2,
	input  var logic [31:0]             request_bytes,
	input  var logic [7:0]              restore_block,
	input  var logic [23:0]             restore_offset,
	input  var logic [BLK_W-1:0]        cur_block,
	input  var logic [OFF_W-1:0]        cur_offset,
	output bba_pkg::result_t            res,
	output logic [BLK_W-1:0]            next_block,
	output logic [OFF_W-1:0]            next_offset
);
	import bba_pkg::*;

	localparam int SW = OFF_W + 2;
	localparam logic [SW-1:0] BLOCK_BYTES = SW'(1) << BLOCK_BYTES_LOG2;

	logic [15:0]    align_mask;
	logic [15:0]    pad;
	logic [SW-1:0]  at;
	logic [SW-1:0]  sum;
	logic           too_large;
	logic           fits;
	logic           last_block;
	logic [BLK_W:0] blk_inc;

	always_comb begin
		align_mask = 16'((17'(1) << align_log2) - 17'd1);
		pad        = (16'd0 - cur_offset[15:0]) & align_mask;
		at         = SW'(cur_offset) + SW'(pad);
		sum        = at + SW'(request_bytes);
		too_large  = {1'b0, request_bytes} > 33'(BLOCK_BYTES);
		fits       = sum <= BLOCK_BYTES;
		blk_inc    = (BLK_W+1)'(cur_block) + (BLK_W+1)'(1);
		last_block = blk_inc >= (BLK_W+1)'(MAX_BLOCKS);
	end

	always_comb begin
		res.status       = ST_OK;
		res.alloc_block  = '0;
		res.alloc_offset = '0;
		next_block       = cur_block;
		next_offset      = cur_offset;
		case (operation)
			OP_RESTORE: begin
				next_block  = BLK_W'(restore_block);
				next_offset = OFF_W'(restore_offset);
			end
			OP_RELEASE: begin
				next_block  = '0;
				next_offset = '0;
			end
			OP_ALLOC: begin
				if (request_bytes == 32'd0) begin
					res.status = ST_NULL;
				end else if (too_large) begin
					res.status = ST_TOO_LARGE;
				end else if (fits) begin
					res.alloc_block  = cur_block[BLK_FIELD_W-1:0];
					res.alloc_offset = at[OFF_FIELD_W-1:0];
					next_offset      = sum[OFF_W-1:0];
				end else if (last_block) begin
					res.status = ST_NO_BLOCKS;
				end else begin
					res.alloc_block = blk_inc[BLK_FIELD_W-1:0];
					next_block      = blk_inc[BLK_W-1:0];
					next_offset     = OFF_W'(request_bytes);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> sv/block_bump_allocator_top.sv
// An accepted input transaction passes through the input register and then the result register to the output.
// Throughput: one transaction per cycle while out_stall is low; the input register and the result register
// form a two-entry pipe, and the frame update is one add/compare pass between them.
// Reset (arst_n low, asynchronous): frame mark cleared to block 0, offset 0,
// both pipe stages emptied.
`timescale 1ns / 1ps
`default_nettype none
module block_bump_allocator_top #(
	parameter int BLOCK_BYTES_LOG2 = 23,
	parameter int MAX_BLOCKS       = 256
) (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        in_valid,
	output logic            in_stall,
	input  var logic [1:0]  operation,
	input  var logic [3:0]  align_log2,
	input  var logic [31:0] request_bytes,
	input  var logic [7:0]  restore_block,
	input  var logic [23:0] restore_offset,
	output logic            out_valid,
	input  var logic        out_stall,
	output logic [1:0]      status,
	output logic [7:0]      alloc_block,
	output logic [23:0]     alloc_offset,
	output logic [7:0]      frame_block,
	output logic [23:0]     frame_offset
);
	import bba_pkg::*;

	localparam int BLK_W = (MAX_BLOCKS > 256) ? $clog2(MAX_BLOCKS) : 8;
	localparam int OFF_W = (BLOCK_BYTES_LOG2 + 1 > 24) ? BLOCK_BYTES_LOG2 + 1 : 24;

	logic              valid_s1;
	op_t               operation_s1;
	logic [3:0]        align_log2_s1;
	logic [31:0]       request_bytes_s1;
	logic [7:0]        restore_block_s1;
	logic [23:0]       restore_offset_s1;

	logic [BLK_W-1:0]  cur_block_q;
	logic [OFF_W-1:0]  cur_offset_q;
	logic              out_valid_q;
	result_t           res_q;

	result_t           res;
	logic [BLK_W-1:0]  next_block;
	logic [OFF_W-1:0]  next_offset;
	logic              advance;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			operation_s1      <= operation;
			align_log2_s1     <= align_log2;
			request_bytes_s1  <= request_bytes;
			restore_block_s1  <= restore_block;
			restore_offset_s1 <= restore_offset;
		end
	end

	bba_step #(
		.BLOCK_BYTES_LOG2 (BLOCK_BYTES_LOG2),
		.MAX_BLOCKS       (MAX_BLOCKS),
		.BLK_W            (BLK_W),
		.OFF_W            (OFF_W)
	) u_step (
		.operation      (operation_s1),
		.align_log2     (align_log2_s1),
		.request_bytes  (request_bytes_s1),
		.restore_block  (restore_block_s1),
		.restore_offset (restore_offset_s1),
		.cur_block      (cur_block_q),
		.cur_offset     (cur_offset_q),
		.res            (res),
		.next_block     (next_block),
		.next_offset    (next_offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			cur_block_q  <= '0;
			cur_offset_q <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				cur_block_q  <= next_block;
				cur_offset_q <= next_offset;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign alloc_block  = res_q.alloc_block;
	assign alloc_offset = res_q.alloc_offset;
	assign frame_block  = cur_block_q[7:0];
	assign frame_offset = cur_offset_q[23:0];

endmodule
`default_nettype wire

>>> sv/bba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bba_checker (
	input var logic        clk,
	input var logic        arst_n,
	input var logic        in_stall,
	input var logic        out_valid,
	input var logic        out_stall,
	input var logic [1:0]  status,
	input var logic [7:0]  alloc_block,
	input var logic [23:0] alloc_offset,
	input var logic [7:0]  frame_block,
	input var logic [23:0] frame_offset
);
	import bba_pkg::*;

	logic [7:0]  last_block_q;
	logic [23:0] last_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_block_q  <= '0;
			last_offset_q <= '0;
		end else if (out_valid && !out_stall) begin
			last_block_q  <= frame_block;
			last_offset_q <= frame_offset;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_block)
			&& $stable(frame_offset))
		else $error("result changed while stalled");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output");

	a_fail_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> alloc_block == 8'd0 && alloc_offset == 24'd0)
		else $error("failed transaction returned an address");

	a_fail_keeps_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK
			|-> frame_block == last_block_q && frame_offset == last_offset_q)
		else $error("failed transaction moved the frame");

	a_alloc_in_frame_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK && (alloc_block != 8'd0 || alloc_offset != 24'd0)
			|-> frame_block == alloc_block)
		else $error("allocation outside current block");

endmodule

bind block_bump_allocator_top bba_checker u_bba_checker (.*);
`default_nettype wire

>>> test/tb_block_bump_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_block_bump_allocator_top;
	import bba_pkg::*;

	localparam op_t OP_UNUSED = 2'd3;
	localparam longint unsigned BLK_BYTES = 64'd1 << 23;
	localparam int MAX_BLK = 256;

	typedef struct packed {
		status_t     st;
		logic [7:0]  ab;
		logic [23:0] ao;
		logic [7:0]  fb;
		logic [23:0] fo;
	} grant_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  lg;
		logic [31:0] nb;
		logic [7:0]  rb;
		logic [23:0] ro;
		logic        known;
		grant_t      exp;
	} req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  operation;
	logic [3:0]  align_log2;
	logic [31:0] request_bytes;
	logic [7:0]  restore_block;
	logic [23:0] restore_offset;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  alloc_block;
	logic [23:0] alloc_offset;
	logic [7:0]  frame_block;
	logic [23:0] frame_offset;

	block_bump_allocator_top i_dut (.*);

	// frame mark as the predictor sees it
	logic [7:0]  mark_blk;
	logic [23:0] mark_off;

	grant_t grant_q[$];
	req_t   dir_rows[$];
	grant_t want;
	logic   calm;
	int     n_err;
	int     n_sent;
	int     st_cnt[4];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic req_t req(op_t op, logic [3:0] lg, logic [31:0] nb,
		logic [7:0] rb, logic [23:0] ro);
		req_t r;
		r = '0;
		r.op = op;
		r.lg = lg;
		r.nb = nb;
		r.rb = rb;
		r.ro = ro;
		return r;
	endfunction

	function automatic req_t req_x(op_t op, logic [3:0] lg, logic [31:0] nb,
		logic [7:0] rb, logic [23:0] ro, status_t st, logic [7:0] ab,
		logic [23:0] ao, logic [7:0] fb, logic [23:0] fo);
		req_t r;
		r = req(op, lg, nb, rb, ro);
		r.known = 1'b1;
		r.exp = '{st: st, ab: ab, ao: ao, fb: fb, fo: fo};
		return r;
	endfunction

	function automatic grant_t bump_predict(req_t r);
		longint unsigned align;
		longint unsigned off;
		longint unsigned pad;
		longint unsigned nb;
		grant_t g;
		g = '0;
		g.st = ST_OK;
		case (r.op)
			OP_RESTORE: begin
				mark_blk = r.rb;
				mark_off = r.ro;
			end
			OP_RELEASE: begin
				mark_blk = '0;
				mark_off = '0;
			end
			OP_ALLOC: begin
				align = 64'd1 << r.lg;
				off = 64'(mark_off);
				pad = (align - (off & (align - 64'd1))) & (align - 64'd1);
				nb = 64'(r.nb);
				if (nb == 64'd0) begin
					g.st = ST_NULL;
				end else if (nb > BLK_BYTES) begin
					g.st = ST_TOO_LARGE;
				end else if (off + pad + nb <= BLK_BYTES) begin
					g.ab = mark_blk;
					g.ao = 24'(off + pad);
					mark_off = 24'(off + pad + nb);
				end else if (int'(mark_blk) + 1 >= MAX_BLK) begin
					g.st = ST_NO_BLOCKS;
				end else begin
					mark_blk = mark_blk + 8'd1;
					mark_off = 24'(nb);
					g.ab = mark_blk;
					g.ao = '0;
				end
			end
			default: ;
		endcase
		g.fb = mark_blk;
		g.fo = mark_off;
		return g;
	endfunction

	function automatic int idle_draw();
		return calm ? 0 : $urandom_range(0, 9);
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int k;
		int s;
		r = req(OP_ALLOC, 4'($urandom), $urandom, 8'($urandom), 24'($urandom));
		k = $urandom_range(0, 99);
		s = $urandom_range(0, 99);
		if (k < 80) begin
			r.op = OP_ALLOC;
			if (s < 3)
				r.nb = '0;
			else if (s < 7)
				r.nb = $urandom_range(32'hFFFF_FFFF, 32'h0080_0001);
			else if (s < 17)
				r.nb = 32'h0080_0000;
			else if (s < 37)
				r.nb = $urandom_range(32'h0010_0000, 32'h0080_0000);
			else
				r.nb = $urandom_range(1, 65536);
		end else if (k < 92) begin
			r.op = OP_RESTORE;
			if ($urandom_range(0, 1))
				r.rb = 8'($urandom_range(250, 255));
			if (s < 60)
				r.ro = 24'($urandom_range(0, 32'h0080_0000));
			else if (s < 75)
				r.ro = 24'h80_0000;
		end else if (k < 97) begin
			r.op = OP_RELEASE;
		end else begin
			r.op = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic send_req(req_t r);
		grant_t g;
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= r.op;
		align_log2     <= r.lg;
		request_bytes  <= r.nb;
		restore_block  <= r.rb;
		restore_offset <= r.ro;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		g = bump_predict(r);
		if (r.known)
			g = r.exp;
		grant_q.push_back(g);
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		wait (grant_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp, act);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (grant_q.size() == 0) begin
				$display("%0t: result with nothing expected, status %0h", $time, status);
				n_err++;
			end else begin
				want = grant_q.pop_front();
				check_field("status", 32'(want.st), 32'(status));
				check_field("alloc_block", 32'(want.ab), 32'(alloc_block));
				check_field("alloc_offset", 32'(want.ao), 32'(alloc_offset));
				check_field("frame_block", 32'(want.fb), 32'(frame_block));
				check_field("frame_offset", 32'(want.fo), 32'(frame_offset));
				st_cnt[status]++;
			end
		end
	end

	// result side back-pressure
	initial begin
		int n;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = idle_draw();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		operation      <= OP_ALLOC;
		align_log2     <= '0;
		request_bytes  <= '0;
		restore_block  <= '0;
		restore_offset <= '0;
		calm = 1'b0;
		n_err = 0;
		n_sent = 0;
		foreach (st_cnt[i]) st_cnt[i] = 0;
		mark_blk = '0;
		mark_off = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows.push_back(req_x(OP_ALLOC, 4'd0, 32'd0, 8'hFF, 24'hFFFFFF,
			ST_NULL, 8'd0, 24'd0, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd15, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF,
			ST_TOO_LARGE, 8'd0, 24'd0, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd0, 32'h0080_0001, 8'd0, 24'd0,
			ST_TOO_LARGE, 8'd0, 24'd0, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd0, 32'd1, 8'd0, 24'd0,
			ST_OK, 8'd0, 24'd0, 8'd0, 24'd1));
		dir_rows.push_back(req(OP_ALLOC, 4'd3, 32'd8, 8'd0, 24'd0));
		dir_rows.push_back(req(OP_ALLOC, 4'd15, 32'd1, 8'd0, 24'd0));
		dir_rows.push_back(req(OP_ALLOC, 4'd0, 32'h0080_0000, 8'd0, 24'd0));
		dir_rows.push_back(req(OP_ALLOC, 4'd0, 32'd1, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_RESTORE, 4'd0, 32'd0, 8'd255, 24'd0,
			ST_OK, 8'd0, 24'd0, 8'd255, 24'd0));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd15, 32'h0080_0000, 8'd0, 24'd0,
			ST_OK, 8'd255, 24'd0, 8'd255, 24'h80_0000));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd0, 32'd1, 8'd0, 24'd0,
			ST_NO_BLOCKS, 8'd0, 24'd0, 8'd255, 24'h80_0000));
		dir_rows.push_back(req_x(OP_RESTORE, 4'd0, 32'd0, 8'd255, 24'hFFFFFF,
			ST_OK, 8'd0, 24'd0, 8'd255, 24'hFFFFFF));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd0, 32'd1, 8'd0, 24'd0,
			ST_NO_BLOCKS, 8'd0, 24'd0, 8'd255, 24'hFFFFFF));
		dir_rows.push_back(req_x(OP_UNUSED, 4'hF, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF,
			ST_OK, 8'd0, 24'd0, 8'd255, 24'hFFFFFF));
		dir_rows.push_back(req_x(OP_RESTORE, 4'hF, 32'hFFFF_FFFF, 8'hAA, 24'h555555,
			ST_OK, 8'd0, 24'd0, 8'hAA, 24'h555555));
		dir_rows.push_back(req_x(OP_RESTORE, 4'h5, 32'h5555_5555, 8'h55, 24'hAAAAAA,
			ST_OK, 8'd0, 24'd0, 8'h55, 24'hAAAAAA));
		// offset past the block end forces the move on the next allocation
		dir_rows.push_back(req(OP_ALLOC, 4'd12, 32'd4096, 8'd0, 24'd0));
		dir_rows.push_back(req(OP_ALLOC, 4'd15, 32'h0080_0000, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_RESTORE, 4'd0, 32'd0, 8'd254, 24'h80_0000,
			ST_OK, 8'd0, 24'd0, 8'd254, 24'h80_0000));
		dir_rows.push_back(req(OP_ALLOC, 4'd0, 32'd1, 8'd0, 24'd0));
		dir_rows.push_back(req(OP_ALLOC, 4'd4, 32'h0080_0000, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_RELEASE, 4'hF, 32'hFFFF_FFFF, 8'hFF, 24'hFFFFFF,
			ST_OK, 8'd0, 24'd0, 8'd0, 24'd0));
		dir_rows.push_back(req_x(OP_ALLOC, 4'd15, 32'h0080_0000, 8'd0, 24'd0,
			ST_OK, 8'd0, 24'd0, 8'd0, 24'h80_0000));
		dir_rows.push_back(req_x(OP_RELEASE, 4'd0, 32'd0, 8'd0, 24'd0,
			ST_OK, 8'd0, 24'd0, 8'd0, 24'd0));

		foreach (dir_rows[i]) send_req(dir_rows[i]);
		drain();

		for (int seg = 0; seg < 13; seg++) begin
			calm = (seg % 4 == 2);
			for (int i = 0; i < 100; i++) send_req(rand_req());
			if (seg == 6)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d transactions: %0d ok, %0d null, %0d too large, %0d out of blocks",
			n_sent, st_cnt[ST_OK], st_cnt[ST_NULL], st_cnt[ST_TOO_LARGE],
			st_cnt[ST_NO_BLOCKS]);
		$display("Mismatches: %0d", n_err);
		if (n_err == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
